// ===== design/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// shared types and constants of the bit-level i2c master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

    localparam int DIVIDER_WIDTH = 16;
    localparam int HP_WIDTH      = 16;
    localparam int CMP_WIDTH     = (DIVIDER_WIDTH > HP_WIDTH) ? DIVIDER_WIDTH : HP_WIDTH;
    localparam logic [HP_WIDTH-1:0] HALF_PERIOD_RESET = 16'd1000;

    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } op_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] wr_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_byte;
    } tick_res_t;

endpackage

`default_nettype wire

// ===== design/i2cbm_core.sv =====
// ----------------------------------------------------------------------------
// i2cbm_core
// bus sequencer state and one-tick step logic of the bit-level i2c master
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_core
    import i2cbm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [HP_WIDTH-1:0] cfg_wr_data,
    input  wire logic                adv,
    input  wire tick_in_t            tick_in,
    output tick_res_t                tick_res
);

    logic [HP_WIDTH-1:0]      half_period_reg;
    op_t                      op_reg, op_next;
    logic                     phase_reg, phase_next;
    logic [3:0]               bit_index_reg, bit_index_next;
    logic [7:0]               shift_reg, shift_next;
    logic [DIVIDER_WIDTH-1:0] tick_reg, tick_next;
    logic                     ack_reg, ack_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;

    logic [CMP_WIDTH-1:0]     hp_ext;
    logic [CMP_WIDTH-1:0]     dmax_ext;
    logic [DIVIDER_WIDTH-1:0] half_eff;
    logic [DIVIDER_WIDTH:0]   tick_inc;
    logic [3:0]               bit_inc;
    logic [7:0]               shift_wr;
    logic                     done;

    // effective half period: saturate to the divider, never zero
    always_comb
    begin
        hp_ext   = CMP_WIDTH'(half_period_reg);
        dmax_ext = CMP_WIDTH'({DIVIDER_WIDTH{1'b1}});
        if (hp_ext > dmax_ext)
        begin
            half_eff = {DIVIDER_WIDTH{1'b1}};
        end
        else
        begin
            half_eff = DIVIDER_WIDTH'(hp_ext);
        end
        if (half_eff == '0)
        begin
            half_eff = DIVIDER_WIDTH'(1);
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        ack_next       = ack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        done           = 1'b0;
        tick_inc       = {1'b0, tick_reg} + {{DIVIDER_WIDTH{1'b0}}, 1'b1};
        bit_inc        = bit_index_reg + 4'd1;
        shift_wr       = {shift_reg[6:0], 1'b0};

        if (op_reg == OP_IDLE)
        begin
            tick_next      = '0;
            phase_next     = 1'b0;
            bit_index_next = '0;
            unique case (tick_in.req_type)
                REQ_START:
                begin
                    op_next  = OP_START;
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                REQ_STOP:
                begin
                    op_next  = OP_STOP;
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                REQ_WRITE:
                begin
                    op_next    = OP_WRITE;
                    shift_next = tick_in.wr_byte;
                    sda_next   = tick_in.wr_byte[7];
                end
                REQ_READ:
                begin
                    op_next    = OP_READ;
                    shift_next = '0;
                    ack_next   = tick_in.send_ack;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (tick_inc >= {1'b0, half_eff})
        begin
            tick_next = '0;
            unique case (op_reg)
                OP_START:
                begin
                    if (!phase_reg)
                    begin
                        sda_next   = 1'b0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        op_next    = OP_IDLE;
                        phase_next = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    if (!phase_reg)
                    begin
                        sda_next   = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        op_next    = OP_IDLE;
                        phase_next = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (!phase_reg)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        phase_next = 1'b0;
                        if (bit_index_reg >= BITS_PER_BYTE)
                        begin
                            op_next        = OP_IDLE;
                            bit_index_next = '0;
                        end
                        else
                        begin
                            shift_next     = shift_wr;
                            bit_index_next = bit_inc;
                            sda_next       = (bit_inc >= BITS_PER_BYTE) ? 1'b1 : shift_wr[7];
                        end
                    end
                end
                OP_READ:
                begin
                    if (!phase_reg)
                    begin
                        scl_next = 1'b0;
                        if (bit_index_reg >= BITS_PER_BYTE)
                        begin
                            op_next        = OP_IDLE;
                            bit_index_next = '0;
                            done           = 1'b1;
                        end
                        else
                        begin
                            shift_next = {shift_reg[6:0], tick_in.sda_in};
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_index_next = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE)
                        begin
                            sda_next = !ack_reg;
                        end
                        scl_next   = 1'b1;
                        phase_next = 1'b0;
                    end
                end
                default:
                begin
                    op_next    = OP_IDLE;
                    phase_next = 1'b0;
                end
            endcase
        end
        else
        begin
            tick_next = tick_inc[DIVIDER_WIDTH-1:0];
        end
    end

    always_comb
    begin
        tick_res.scl_out  = scl_next;
        tick_res.sda_out  = sda_next;
        tick_res.busy_res = (op_next != OP_IDLE);
        tick_res.rd_valid = done;
        tick_res.rd_byte  = done ? shift_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_IDLE;
            phase_reg     <= 1'b0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            tick_reg      <= '0;
            ack_reg       <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (adv)
        begin
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            ack_reg       <= ack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2c_bit_level_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// bit-level i2c master paced by one input item per divider tick
//
// input channel (in_valid / in_ready): one item is one tick; it carries the
// sampled sda level and, while the master is idle, a command in req_type
// (start, stop, write byte, read byte with ack or nack). commands that arrive
// while busy are ignored.
// output channel (out_valid / out_ready): exactly one item per input item,
// giving the scl and sda levels after that tick, the busy flag and a one-tick
// rd_valid strobe with the read byte.
// the output is valid in the cycle after input accept; throughput is one
// item per cycle while out_ready is high, set by the single result register.
// half_period is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while idle (unenforced). reset: both lines released, sequencer idle,
// half_period back to 1000. when the receiver stalls, the result is held and
// in_ready drops until the result register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [HP_WIDTH-1:0] cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          req_type,
    input  wire logic [7:0]          wr_byte,
    input  wire logic                send_ack,
    input  wire logic                sda_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     scl_out,
    output logic                     sda_out,
    output logic                     busy_res,
    output logic                     rd_valid,
    output logic [7:0]               rd_byte
);

    tick_in_t  tick_in;
    tick_res_t tick_res;
    tick_res_t res_reg;
    logic      out_valid_reg;
    logic      adv;

    assign in_ready = !out_valid_reg || out_ready;
    assign adv      = in_valid && in_ready;

    assign tick_in.req_type = req_type;
    assign tick_in.wr_byte  = wr_byte;
    assign tick_in.send_ack = send_ack;
    assign tick_in.sda_in   = sda_in;

    i2cbm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .adv         (adv),
        .tick_in     (tick_in),
        .tick_res    (tick_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= tick_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = res_reg.scl_out;
    assign sda_out   = res_reg.sda_out;
    assign busy_res  = res_reg.busy_res;
    assign rd_valid  = res_reg.rd_valid;
    assign rd_byte   = res_reg.rd_byte;

endmodule

`default_nettype wire

// ===== design/i2cbm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cbm_checker
// port-level checks of the bit-level i2c master
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_checker
    import i2cbm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic [2:0]          req_type,
    input wire logic [7:0]          wr_byte,
    input wire logic                send_ack,
    input wire logic                sda_in,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                scl_out,
    input wire logic                sda_out,
    input wire logic                busy_res,
    input wire logic                rd_valid,
    input wire logic [7:0]          rd_byte
);

    // every accepted item yields a result on the next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // a finished read leaves the master idle on the same tick
    a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rd_valid |-> !busy_res)
        else $error("read strobe while busy");

    // read byte is zero outside the strobe
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rd_valid |-> rd_byte == 8'd0)
        else $error("read byte set without strobe");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scl_out) && $stable(sda_out)
            && $stable(busy_res) && $stable(rd_valid) && $stable(rd_byte))
        else $error("stalled result changed");

    // waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(wr_byte)
            && $stable(send_ack) && $stable(sda_in))
        else $error("waiting input item changed");

endmodule

bind i2c_bit_level_master i2cbm_checker u_checker (.*);

`default_nettype wire
